/* src/vtyp_pkg.sv */
// ----------------------------------------------------------------------------
// vtyp_pkg
// shared constants, types and the cordic angle table of the yaw/pitch block
// ----------------------------------------------------------------------------
package vtyp_pkg;

	localparam int ANGLE_FRAC_BITS = 7;
	localparam int ACC_FRAC        = 16;
	localparam int ROUND_SHIFT     = ACC_FRAC - ANGLE_FRAC_BITS;
	localparam int CORDIC_STEPS    = 23;
	localparam int SQRT_STEPS      = 32;
	localparam int FRONT_STAGES    = 5;
	localparam int PIPE_STAGES     = FRONT_STAGES + SQRT_STEPS + CORDIC_STEPS + 1;
	localparam int XW              = 36;
	localparam int ZW              = 25;
	localparam int AW              = 18;

	localparam logic [AW-1:0] ANG_FULL    = AW'(360 << ANGLE_FRAC_BITS);
	localparam logic [AW-1:0] ANG_HALF    = AW'(180 << ANGLE_FRAC_BITS);
	localparam logic [AW-1:0] ANG_QUARTER = AW'(90 << ANGLE_FRAC_BITS);
	localparam logic signed [ZW-1:0] Z_TOP = ZW'(90 << ACC_FRAC);
	localparam logic signed [ZW-1:0] Z_HALF_LSB = ZW'(1 << (ROUND_SHIFT - 1));

	typedef logic signed [XW-1:0] cxy_t;
	typedef logic signed [ZW-1:0] cz_t;

	typedef struct packed {
		logic [30:0] ya;
		logic [30:0] yb;
		logic [30:0] pa;
		logic        y_a0;
		logic        y_b0;
		logic        p_a0;
		logic        p_b0;
		logic        sx_le0;
		logic        sy_neg;
		logic        sz_pos;
	} side_t;

	function automatic cz_t atan_q16(input logic [4:0] i);
		cz_t v;
		case (i)
			5'd0:    v = ZW'(2949120);
			5'd1:    v = ZW'(1740967);
			5'd2:    v = ZW'(919879);
			5'd3:    v = ZW'(466945);
			5'd4:    v = ZW'(234379);
			5'd5:    v = ZW'(117304);
			5'd6:    v = ZW'(58666);
			5'd7:    v = ZW'(29335);
			5'd8:    v = ZW'(14668);
			5'd9:    v = ZW'(7334);
			5'd10:   v = ZW'(3667);
			5'd11:   v = ZW'(1833);
			5'd12:   v = ZW'(917);
			5'd13:   v = ZW'(458);
			5'd14:   v = ZW'(229);
			5'd15:   v = ZW'(115);
			5'd16:   v = ZW'(57);
			5'd17:   v = ZW'(29);
			5'd18:   v = ZW'(14);
			5'd19:   v = ZW'(7);
			5'd20:   v = ZW'(4);
			5'd21:   v = ZW'(2);
			5'd22:   v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* src/vtyp_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// vtyp_sqrt_cell
// one digit step of the integer square root, registered
// ----------------------------------------------------------------------------
module vtyp_sqrt_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [4:0]  step,
	input  logic [63:0] n_in,
	input  logic [63:0] r_in,
	output logic [63:0] n_out,
	output logic [63:0] r_out
);

	logic [6:0]  sh;
	logic [63:0] bit_v;
	logic [63:0] t;

	assign sh    = 7'd62 - {1'b0, step, 1'b0};
	assign bit_v = 64'd1 << sh;
	assign t     = r_in + bit_v;

	always_ff @(posedge clk) begin
		if (en) begin
			if (n_in >= t) begin
				n_out <= n_in - t;
				r_out <= (r_in >> 1) + bit_v;
			end else begin
				n_out <= n_in;
				r_out <= r_in >> 1;
			end
		end
	end

endmodule

/* src/vtyp_cordic_cell.sv */
// ----------------------------------------------------------------------------
// vtyp_cordic_cell
// one vectoring rotation of the cordic, angle kept in degrees q.16
// ----------------------------------------------------------------------------
module vtyp_cordic_cell (
	input  logic               clk,
	input  logic               en,
	input  logic [4:0]         step,
	input  vtyp_pkg::cxy_t     x_in,
	input  vtyp_pkg::cxy_t     y_in,
	input  vtyp_pkg::cz_t      z_in,
	output vtyp_pkg::cxy_t     x_out,
	output vtyp_pkg::cxy_t     y_out,
	output vtyp_pkg::cz_t      z_out
);

	vtyp_pkg::cxy_t sx;
	vtyp_pkg::cxy_t sy;
	vtyp_pkg::cz_t  at;

	assign sx = x_in >>> step;
	assign sy = y_in >>> step;
	assign at = vtyp_pkg::atan_q16(step);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[vtyp_pkg::XW-1]) begin
				x_out <= x_in + sy;
				y_out <= y_in - sx;
				z_out <= z_in + at;
			end else begin
				x_out <= x_in - sy;
				y_out <= y_in + sx;
				z_out <= z_in - at;
			end
		end
	end

endmodule

/* src/vector_to_yaw_pitch_top.sv */
// ----------------------------------------------------------------------------
// vector_to_yaw_pitch_top
// aims an observer at a target point and gives yaw and pitch in 1/128 degree
// ----------------------------------------------------------------------------
// A new item is taken every cycle while the output side keeps up. The row
// is made of five front stages (difference, magnitude, normalize, square,
// sum), a row of 32 square root cells and two parallel rows of 23 cordic
// cells, then one output register. The whole row moves together, so a
// stalled output holds the input side.
module vector_to_yaw_pitch_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// own_x, own_y, own_z, head_x, head_y, head_z, body_x, body_y, body_z
	input  logic [287:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// yaw[15:0], pitch[30:16], zero pad
	output logic [31:0]  m_tdata
);

	localparam int LAST = vtyp_pkg::PIPE_STAGES - 1;
	localparam int NS   = vtyp_pkg::SQRT_STEPS;
	localparam int NC   = vtyp_pkg::CORDIC_STEPS;

	logic en;
	logic [vtyp_pkg::PIPE_STAGES-1:0] vld_q;

	assign en       = !vld_q[LAST] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAST-1:0], s_tvalid};
		end
	end

	// difference
	logic signed [31:0] own_x, own_y, own_z, head_x, head_y, head_z, body_x, body_y, body_z;
	logic signed [31:0] tx, ty, tz;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;

	assign own_x  = s_tdata[31:0];
	assign own_y  = s_tdata[63:32];
	assign own_z  = s_tdata[95:64];
	assign head_x = s_tdata[127:96];
	assign head_y = s_tdata[159:128];
	assign head_z = s_tdata[191:160];
	assign body_x = s_tdata[223:192];
	assign body_y = s_tdata[255:224];
	assign body_z = s_tdata[287:256];

	assign tx = head_x[31] ? body_x : head_x;
	assign ty = head_x[31] ? body_y : head_y;
	assign tz = head_x[31] ? body_z : head_z;

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= {own_x[31], own_x} - {tx[31], tx};
			dy_s1 <= {own_y[31], own_y} - {ty[31], ty};
			dz_s1 <= {own_z[31], own_z} - {tz[31], tz};
		end
	end

	// magnitudes and shift amounts
	logic [32:0] mx, my, mz, ymax, pmax, mx_s2, my_s2, mz_s2;
	logic [1:0]  yrsh, prsh, yrsh_s2, prsh_s2;
	logic [4:0]  ylsh, plsh, ylsh_s2, plsh_s2;
	logic        sx_le0_s2, sy_neg_s2, sz_pos_s2;

	assign mx   = dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
	assign my   = dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
	assign mz   = dz_s1[32] ? 33'(-dz_s1) : 33'(dz_s1);
	assign ymax = (mx > my) ? mx : my;
	assign pmax = (mz > ymax) ? mz : ymax;

	always_comb begin
		logic [5:0] ym;
		logic [5:0] pm;
		ym = '0;
		pm = '0;
		for (int i = 0; i < 33; i++) begin
			if (ymax[i]) ym = 6'(i);
			if (pmax[i]) pm = 6'(i);
		end
		yrsh = (ym == 6'd32) ? 2'd2 : ((ym == 6'd31) ? 2'd1 : 2'd0);
		prsh = (pm == 6'd32) ? 2'd2 : ((pm == 6'd31) ? 2'd1 : 2'd0);
		ylsh = (ym <= 6'd30) ? 5'(6'd30 - ym) : 5'd0;
		plsh = (pm <= 6'd30) ? 5'(6'd30 - pm) : 5'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2     <= mx;
			my_s2     <= my;
			mz_s2     <= mz;
			yrsh_s2   <= yrsh;
			prsh_s2   <= prsh;
			ylsh_s2   <= ylsh;
			plsh_s2   <= plsh;
			sx_le0_s2 <= dx_s1[32] || (dx_s1 == '0);
			sy_neg_s2 <= dy_s1[32];
			sz_pos_s2 <= !dz_s1[32] && (dz_s1 != '0);
		end
	end

	// normalize
	logic [63:0] yan, ybn, pxn, pyn, pzn;
	logic [30:0] px_s3, py_s3;
	vtyp_pkg::side_t side_s3, side_s4, side_s5;
	vtyp_pkg::side_t side_c;

	assign yan = ({31'd0, mx_s2} >> yrsh_s2) << ylsh_s2;
	assign ybn = ({31'd0, my_s2} >> yrsh_s2) << ylsh_s2;
	assign pxn = ({31'd0, mx_s2} >> prsh_s2) << plsh_s2;
	assign pyn = ({31'd0, my_s2} >> prsh_s2) << plsh_s2;
	assign pzn = ({31'd0, mz_s2} >> prsh_s2) << plsh_s2;

	always_comb begin
		side_c        = '0;
		side_c.ya     = yan[30:0];
		side_c.yb     = ybn[30:0];
		side_c.pa     = pzn[30:0];
		side_c.y_a0   = (yan[30:0] == '0);
		side_c.y_b0   = (ybn[30:0] == '0);
		side_c.p_a0   = (pzn[30:0] == '0);
		side_c.sx_le0 = sx_le0_s2;
		side_c.sy_neg = sy_neg_s2;
		side_c.sz_pos = sz_pos_s2;
	end

	// squares and sum
	logic [61:0] sqx_s4, sqy_s4;
	logic [63:0] n_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s3   <= pxn[30:0];
			py_s3   <= pyn[30:0];
			side_s3 <= side_c;
			sqx_s4  <= px_s3 * px_s3;
			sqy_s4  <= py_s3 * py_s3;
			side_s4 <= side_s3;
			n_s5    <= {2'b00, sqx_s4} + {2'b00, sqy_s4};
			side_s5 <= side_s4;
		end
	end

	// square root row
	logic [63:0] sn [NS];
	logic [63:0] sr [NS];
	vtyp_pkg::side_t sside_q [NS];

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		vtyp_sqrt_cell u_cell (
			.clk   (clk),
			.en    (en),
			.step  (5'(k)),
			.n_in  ((k == 0) ? n_s5 : sn[(k == 0) ? 0 : k - 1]),
			.r_in  ((k == 0) ? 64'd0 : sr[(k == 0) ? 0 : k - 1]),
			.n_out (sn[k]),
			.r_out (sr[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sside_q[0] <= side_s5;
			for (int k = 1; k < NS; k++) sside_q[k] <= sside_q[k-1];
		end
	end

	// cordic rows
	vtyp_pkg::side_t side_e;
	vtyp_pkg::side_t cside_q [NC];
	vtyp_pkg::cxy_t  yx [NC];
	vtyp_pkg::cxy_t  yy [NC];
	vtyp_pkg::cz_t   yz [NC];
	vtyp_pkg::cxy_t  px [NC];
	vtyp_pkg::cxy_t  py [NC];
	vtyp_pkg::cz_t   pz [NC];
	vtyp_pkg::cxy_t  yx0, yy0, px0, py0;

	always_comb begin
		side_e      = sside_q[NS-1];
		side_e.p_b0 = (sr[NS-1] == '0);
	end

	assign yx0 = vtyp_pkg::cxy_t'({5'd0, sside_q[NS-1].yb});
	assign yy0 = vtyp_pkg::cxy_t'({5'd0, sside_q[NS-1].ya});
	assign px0 = vtyp_pkg::cxy_t'({4'd0, sr[NS-1][31:0]});
	assign py0 = vtyp_pkg::cxy_t'({5'd0, sside_q[NS-1].pa});

	for (genvar k = 0; k < NC; k++) begin : g_cordic
		vtyp_cordic_cell u_yaw (
			.clk   (clk),
			.en    (en),
			.step  (5'(k)),
			.x_in  ((k == 0) ? yx0 : yx[(k == 0) ? 0 : k - 1]),
			.y_in  ((k == 0) ? yy0 : yy[(k == 0) ? 0 : k - 1]),
			.z_in  ((k == 0) ? vtyp_pkg::cz_t'(0) : yz[(k == 0) ? 0 : k - 1]),
			.x_out (yx[k]),
			.y_out (yy[k]),
			.z_out (yz[k])
		);
		vtyp_cordic_cell u_pitch (
			.clk   (clk),
			.en    (en),
			.step  (5'(k)),
			.x_in  ((k == 0) ? px0 : px[(k == 0) ? 0 : k - 1]),
			.y_in  ((k == 0) ? py0 : py[(k == 0) ? 0 : k - 1]),
			.z_in  ((k == 0) ? vtyp_pkg::cz_t'(0) : pz[(k == 0) ? 0 : k - 1]),
			.x_out (px[k]),
			.y_out (py[k]),
			.z_out (pz[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cside_q[0] <= side_e;
			for (int k = 1; k < NC; k++) cside_q[k] <= cside_q[k-1];
		end
	end

	// rounding and quadrant
	function automatic logic [vtyp_pkg::AW-1:0] round_ang(input vtyp_pkg::cz_t z);
		vtyp_pkg::cz_t zc;
		vtyp_pkg::cz_t zr;
		zc = z;
		if (z < 0) zc = '0;
		if (z > vtyp_pkg::Z_TOP) zc = vtyp_pkg::Z_TOP;
		zr = (zc + vtyp_pkg::Z_HALF_LSB) >>> vtyp_pkg::ROUND_SHIFT;
		return vtyp_pkg::AW'(zr);
	endfunction

	vtyp_pkg::side_t sf;
	logic [vtyp_pkg::AW-1:0] yphi, pphi, yraw, yfin;
	logic [15:0] yaw_q;
	logic signed [14:0] pitch_q, pitch_c;

	assign sf = cside_q[NC-1];

	always_comb begin
		if (sf.y_a0)      yphi = '0;
		else if (sf.y_b0) yphi = vtyp_pkg::ANG_QUARTER;
		else              yphi = round_ang(yz[NC-1]);
		if (sf.p_a0)      pphi = '0;
		else if (sf.p_b0) pphi = vtyp_pkg::ANG_QUARTER;
		else              pphi = round_ang(pz[NC-1]);
		if (!sf.sy_neg) yraw = sf.sx_le0 ? yphi : vtyp_pkg::ANG_FULL - yphi;
		else            yraw = sf.sx_le0 ? vtyp_pkg::ANG_HALF - yphi
		                                 : vtyp_pkg::ANG_HALF + yphi;
		yfin    = (yraw >= vtyp_pkg::ANG_FULL) ? yraw - vtyp_pkg::ANG_FULL : yraw;
		pitch_c = sf.sz_pos ? -15'(pphi) : 15'(pphi);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_q   <= yfin[15:0];
			pitch_q <= pitch_c;
		end
	end

	assign m_tdata = {1'b0, pitch_q, yaw_q};

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[15:0] < 16'd46080))
		else $error("yaw out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd11520 &&
		              $signed(m_tdata[30:16]) >= -15'sd11520))
		else $error("pitch out of range");

	a_stall_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while row is stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted item lost at entry");

endmodule
